// ----- rtl/core/rtttl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the RTTTL melody parser.
package rtttl_pkg;

    localparam int CHAR_W     = 8;
    localparam int NUM_W      = 16;
    localparam int SEMI_W     = 4;
    localparam int OCT_W      = 4;
    localparam int DEF_OCT_W  = 3;
    localparam int WHOLE_W    = 18;
    localparam int DUR_W      = 19;
    localparam int TONE_W     = 6;
    localparam int DIV_STEPS  = WHOLE_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [NUM_W-1:0]     NUM_MAX         = 16'hFFFF;
    localparam logic [NUM_W-1:0]     DEF_LENGTH_RST  = 16'd4;
    localparam logic [DEF_OCT_W-1:0] DEF_OCTAVE_RST  = 3'd6;
    localparam logic [NUM_W-1:0]     TEMPO_RST       = 16'd63;
    localparam logic [WHOLE_W-1:0]   MS_PER_MINUTE   = 18'd60000;
    localparam logic [6:0]           TONE_OFFSET     = 7'd48;
    localparam logic [6:0]           TONE_FIRST_RAW  = 7'd49;
    localparam logic [6:0]           TONE_LAST_RAW   = 7'd96;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LC_C  = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LC_D  = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LC_E  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_G  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LC_O  = 8'h6F;

    typedef enum logic [1:0] {
        CMD_TEMPO    = 2'd0,
        CMD_NOTE     = 2'd1,
        CMD_REST_END = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [NUM_W-1:0]      num;
        logic [SEMI_W-1:0]     semitone;
        logic                  dotted;
        logic [OCT_W-1:0]      octave;
        logic                  last;
    } t_cmd;

    function automatic logic [SEMI_W-1:0] semitone_of(input logic [CHAR_W-1:0] c);
        logic [SEMI_W-1:0] s;
        case (c)
            CH_LC_C: s = 4'd1;
            CH_LC_D: s = 4'd3;
            CH_LC_E: s = 4'd5;
            CH_LC_F: s = 4'd6;
            CH_LC_G: s = 4'd8;
            CH_LC_A: s = 4'd10;
            CH_LC_B: s = 4'd12;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- rtl/core/rtttl_front.sv -----
`timescale 1ns / 1ps
// Character parser that reads the header and notes and issues commands to the queue.
module rtttl_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rtttl_pkg::CHAR_W-1:0]      i_char_code,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output rtttl_pkg::t_cmd                   o_push_cmd
);

    typedef enum logic [15:0] {
        PH_SKIP_NAME = 16'h0001,
        PH_D         = 16'h0002,
        PH_D_SKIP    = 16'h0004,
        PH_D_NUM     = 16'h0008,
        PH_O         = 16'h0010,
        PH_O_SKIP    = 16'h0020,
        PH_O_DIG     = 16'h0040,
        PH_O_SEP     = 16'h0080,
        PH_B         = 16'h0100,
        PH_B_SKIP    = 16'h0200,
        PH_B_NUM     = 16'h0400,
        PH_N_DUR     = 16'h0800,
        PH_N_LETTER  = 16'h1000,
        PH_N_SHARP   = 16'h2000,
        PH_N_DOT     = 16'h4000,
        PH_N_OCT     = 16'h8000
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [rtttl_pkg::NUM_W-1:0]         r_accum, n_accum;
    logic [rtttl_pkg::NUM_W-1:0]         r_def_len, n_def_len;
    logic [rtttl_pkg::DEF_OCT_W-1:0]     r_def_oct, n_def_oct;
    logic [rtttl_pkg::NUM_W-1:0]         r_bpm, n_bpm;
    logic [rtttl_pkg::SEMI_W-1:0]        r_semi, n_semi;
    logic                                r_dot, n_dot;
    logic [rtttl_pkg::OCT_W-1:0]         r_oct, n_oct;

    logic                                accept;
    logic                                digit;
    logic [rtttl_pkg::NUM_W-1:0]         digit_val;
    logic [19:0]                         acc_wide;
    logic [rtttl_pkg::NUM_W-1:0]         acc_next;
    logic                                note_pending;
    logic [rtttl_pkg::NUM_W-1:0]         note_len;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign digit      = rtttl_pkg::is_digit(i_char_code);
    assign digit_val  = {{(rtttl_pkg::NUM_W-4){1'b0}}, 4'(i_char_code - rtttl_pkg::CH_ZERO)};
    assign acc_wide   = 20'(r_accum) * 20'd10 + 20'(digit_val);
    assign acc_next   = (acc_wide[19:16] != 4'd0) ? rtttl_pkg::NUM_MAX : acc_wide[15:0];
    assign note_len   = (r_accum != '0) ? r_accum : r_def_len;
    assign note_pending = (r_phase == PH_N_LETTER) || (r_phase == PH_N_SHARP) ||
                          (r_phase == PH_N_DOT) || (r_phase == PH_N_OCT);

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_def_len = r_def_len;
        n_def_oct = r_def_oct;
        n_bpm     = r_bpm;
        n_semi    = r_semi;
        n_dot     = r_dot;
        n_oct     = r_oct;
        o_push    = 1'b0;
        o_push_cmd.kind     = rtttl_pkg::CMD_NOTE;
        o_push_cmd.num      = note_len;
        o_push_cmd.semitone = r_semi;
        o_push_cmd.dotted   = r_dot;
        o_push_cmd.octave   = r_oct;
        o_push_cmd.last     = 1'b0;
        if (accept) begin
            if (i_char_code == rtttl_pkg::CH_NUL) begin
                o_push = 1'b1;
                o_push_cmd.last = 1'b1;
                if (!note_pending) begin
                    o_push_cmd.kind     = rtttl_pkg::CMD_REST_END;
                    o_push_cmd.semitone = '0;
                    o_push_cmd.dotted   = 1'b0;
                end
                n_phase   = PH_SKIP_NAME;
                n_accum   = '0;
                n_def_len = rtttl_pkg::DEF_LENGTH_RST;
                n_def_oct = rtttl_pkg::DEF_OCTAVE_RST;
                n_bpm     = rtttl_pkg::TEMPO_RST;
                n_semi    = '0;
                n_dot     = 1'b0;
                n_oct     = '0;
            end else begin
                case (r_phase)
                    PH_SKIP_NAME: begin
                        if (i_char_code == rtttl_pkg::CH_COLON) begin
                            n_phase = PH_D;
                        end
                    end
                    PH_D, PH_O, PH_B: begin
                        if (r_phase == PH_D && i_char_code == rtttl_pkg::CH_LC_D) begin
                            n_phase = PH_D_SKIP;
                        end else if (r_phase != PH_B && i_char_code == rtttl_pkg::CH_LC_O) begin
                            n_phase = PH_O_SKIP;
                        end else if (i_char_code == rtttl_pkg::CH_LC_B) begin
                            n_phase = PH_B_SKIP;
                        end else begin
                            o_push = 1'b1;
                            o_push_cmd.kind = rtttl_pkg::CMD_TEMPO;
                            o_push_cmd.num  = r_bpm;
                            if (digit) begin
                                n_accum = digit_val;
                                n_phase = PH_N_DUR;
                            end else begin
                                n_accum = '0;
                                n_semi  = rtttl_pkg::semitone_of(i_char_code);
                                n_dot   = 1'b0;
                                n_oct   = {1'b0, r_def_oct};
                                n_phase = PH_N_LETTER;
                            end
                        end
                    end
                    PH_D_SKIP: begin
                        n_accum = '0;
                        n_phase = PH_D_NUM;
                    end
                    PH_D_NUM: begin
                        if (digit) begin
                            n_accum = acc_next;
                        end else begin
                            if (r_accum != '0) begin
                                n_def_len = r_accum;
                            end
                            n_accum = '0;
                            n_phase = PH_O;
                        end
                    end
                    PH_O_SKIP: begin
                        n_phase = PH_O_DIG;
                    end
                    PH_O_DIG: begin
                        if (i_char_code >= rtttl_pkg::CH_THREE &&
                            i_char_code <= rtttl_pkg::CH_SEVEN) begin
                            n_def_oct = 3'(i_char_code - rtttl_pkg::CH_ZERO);
                        end
                        n_phase = PH_O_SEP;
                    end
                    PH_O_SEP: begin
                        n_phase = PH_B;
                    end
                    PH_B_SKIP: begin
                        n_accum = '0;
                        n_phase = PH_B_NUM;
                    end
                    PH_B_NUM: begin
                        if (digit) begin
                            n_accum = acc_next;
                        end else begin
                            n_bpm   = r_accum;
                            o_push  = 1'b1;
                            o_push_cmd.kind = rtttl_pkg::CMD_TEMPO;
                            o_push_cmd.num  = r_accum;
                            n_accum = '0;
                            n_phase = PH_N_DUR;
                        end
                    end
                    PH_N_DUR: begin
                        if (digit) begin
                            n_accum = acc_next;
                        end else begin
                            n_semi  = rtttl_pkg::semitone_of(i_char_code);
                            n_dot   = 1'b0;
                            n_oct   = {1'b0, r_def_oct};
                            n_phase = PH_N_LETTER;
                        end
                    end
                    PH_N_LETTER, PH_N_SHARP, PH_N_DOT, PH_N_OCT: begin
                        if (r_phase == PH_N_LETTER && i_char_code == rtttl_pkg::CH_HASH) begin
                            n_semi  = r_semi + 4'd1;
                            n_phase = PH_N_SHARP;
                        end else if ((r_phase == PH_N_LETTER || r_phase == PH_N_SHARP) &&
                                     i_char_code == rtttl_pkg::CH_DOT) begin
                            n_dot   = 1'b1;
                            n_phase = PH_N_DOT;
                        end else if (r_phase != PH_N_OCT && digit) begin
                            n_oct   = digit_val[rtttl_pkg::OCT_W-1:0];
                            n_phase = PH_N_OCT;
                        end else begin
                            o_push  = 1'b1;
                            n_accum = '0;
                            n_semi  = '0;
                            n_dot   = 1'b0;
                            n_oct   = '0;
                            if (i_char_code == rtttl_pkg::CH_COMMA) begin
                                n_phase = PH_N_DUR;
                            end else if (digit) begin
                                n_accum = digit_val;
                                n_phase = PH_N_DUR;
                            end else begin
                                n_semi  = rtttl_pkg::semitone_of(i_char_code);
                                n_oct   = {1'b0, r_def_oct};
                                n_phase = PH_N_LETTER;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP_NAME;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP_NAME;
            r_accum   <= '0;
            r_def_len <= rtttl_pkg::DEF_LENGTH_RST;
            r_def_oct <= rtttl_pkg::DEF_OCTAVE_RST;
            r_bpm     <= rtttl_pkg::TEMPO_RST;
            r_semi    <= '0;
            r_dot     <= 1'b0;
            r_oct     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_def_len <= n_def_len;
            r_def_oct <= n_def_oct;
            r_bpm     <= n_bpm;
            r_semi    <= n_semi;
            r_dot     <= n_dot;
            r_oct     <= n_oct;
        end
    end

endmodule

// ----- rtl/core/rtttl_queue.sv -----
`timescale 1ns / 1ps
// Small command queue that decouples the parser from the timing unit.
module rtttl_queue #(
    parameter int DEPTH = rtttl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rtttl_pkg::t_cmd      i_push_cmd,
    output logic                 o_full,
    input  logic                 i_pop,
    output rtttl_pkg::t_cmd      o_head_cmd,
    output logic                 o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rtttl_pkg::t_cmd     r_entry [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                do_push, do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_head_cmd = r_entry[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/core/rtttl_back.sv -----
`timescale 1ns / 1ps
// Timing unit that divides out whole-note time and note lengths, forms tone indices and holds the result register.
module rtttl_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  rtttl_pkg::t_cmd                   i_head_cmd,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rtttl_pkg::TONE_W-1:0]      o_tone_index,
    output logic [rtttl_pkg::DUR_W-1:0]       o_duration_ms,
    output logic                              o_index_invalid,
    output logic                              o_end_of_song
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                               r_state;
    rtttl_pkg::t_cmd                      r_cmd;
    logic [rtttl_pkg::WHOLE_W-1:0]        r_whole;
    logic [rtttl_pkg::WHOLE_W-1:0]        r_quo;
    logic [rtttl_pkg::NUM_W-1:0]          r_rem;
    logic [rtttl_pkg::NUM_W-1:0]          r_divisor;
    logic [rtttl_pkg::STEP_W-1:0]         r_step;
    logic                                 r_out_valid;
    logic [rtttl_pkg::TONE_W-1:0]         r_tone;
    logic [rtttl_pkg::DUR_W-1:0]          r_dur;
    logic                                 r_inv;
    logic                                 r_end;

    logic [rtttl_pkg::NUM_W:0]            trial;
    logic                                 fits;
    logic [rtttl_pkg::WHOLE_W-1:0]        quo_next;
    logic [rtttl_pkg::NUM_W-1:0]          rem_next;
    logic                                 load_out;
    logic [6:0]                           raw_index;
    logic                                 raw_ok;
    logic [rtttl_pkg::DUR_W-1:0]          dur_val;

    assign trial    = {r_rem, r_quo[rtttl_pkg::WHOLE_W-1]};
    assign fits     = trial >= {1'b0, r_divisor};
    assign rem_next = fits ? rtttl_pkg::NUM_W'(trial - {1'b0, r_divisor})
                           : trial[rtttl_pkg::NUM_W-1:0];
    assign quo_next = {r_quo[rtttl_pkg::WHOLE_W-2:0], fits};

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign load_out = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    assign raw_index = 7'(r_cmd.octave) * 7'd12 + 7'(r_cmd.semitone);
    assign raw_ok    = (raw_index >= rtttl_pkg::TONE_FIRST_RAW) &&
                       (raw_index <= rtttl_pkg::TONE_LAST_RAW);
    assign dur_val   = r_cmd.dotted ? 19'(r_quo) + 19'(r_quo >> 1) : 19'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_whole     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_cmd  <= i_head_cmd;
                        r_rem  <= '0;
                        r_step <= rtttl_pkg::STEP_W'(rtttl_pkg::DIV_STEPS);
                        case (i_head_cmd.kind)
                            rtttl_pkg::CMD_TEMPO: begin
                                r_quo     <= rtttl_pkg::MS_PER_MINUTE;
                                r_divisor <= (i_head_cmd.num == '0) ?
                                             rtttl_pkg::NUM_W'(1) : i_head_cmd.num;
                                r_state   <= ST_DIV;
                            end
                            rtttl_pkg::CMD_NOTE: begin
                                r_quo     <= r_whole;
                                r_divisor <= i_head_cmd.num;
                                r_state   <= ST_DIV;
                            end
                            default: begin
                                r_quo     <= '0;
                                r_state   <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem  <= rem_next;
                    r_quo  <= quo_next;
                    r_step <= r_step - 1'b1;
                    if (r_step == rtttl_pkg::STEP_W'(1)) begin
                        if (r_cmd.kind == rtttl_pkg::CMD_TEMPO) begin
                            r_whole <= {quo_next[rtttl_pkg::WHOLE_W-3:0], 2'b00};
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (load_out) begin
                        if (r_cmd.last) begin
                            r_whole <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_dur <= dur_val;
            r_end <= r_cmd.last;
            if (r_cmd.semitone == '0) begin
                r_tone <= '0;
                r_inv  <= 1'b0;
            end else if (raw_ok) begin
                r_tone <= rtttl_pkg::TONE_W'(raw_index - rtttl_pkg::TONE_OFFSET);
                r_inv  <= 1'b0;
            end else begin
                r_tone <= '0;
                r_inv  <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tone_index    = r_tone;
    assign o_duration_ms   = r_dur;
    assign o_index_invalid = r_inv;
    assign o_end_of_song   = r_end;

endmodule

// ----- rtl/core/rtttl_melody_parser.sv -----
`timescale 1ns / 1ps
// Top level of the RTTTL melody parser: parser, command queue and timing unit.
// The parser takes one ringtone character per clock cycle and stalls only when the
// command queue is full. Every completed note and every end of header goes through the
// queue to a timing unit whose restoring divider produces one quotient bit a cycle. It
// fetches a note, divides and then writes the result register; a tempo update is only
// fetched and divided. It takes a new command only once it is done with the last; the
// queue absorbs short bursts, and when notes arrive faster than the timing unit handles
// them the parser waits once the queue is full. A zero byte with no note pending passes
// the queue, command register and result register to its end-of-song result once the
// queue ahead has drained and the receiver is ready; else the pending note is last.
module rtttl_melody_parser #(
    parameter int QUEUE_DEPTH = rtttl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rtttl_pkg::CHAR_W-1:0]      i_char_code,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rtttl_pkg::TONE_W-1:0]      o_tone_index,
    output logic [rtttl_pkg::DUR_W-1:0]       o_duration_ms,
    output logic                              o_index_invalid,
    output logic                              o_end_of_song
);

    logic              w_push;
    rtttl_pkg::t_cmd   w_push_cmd;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    rtttl_pkg::t_cmd   w_head_cmd;

    rtttl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_cmd   (w_push_cmd)
    );

    rtttl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head_cmd (w_head_cmd),
        .o_empty    (w_empty)
    );

    rtttl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_head_cmd      (w_head_cmd),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tone_index    (o_tone_index),
        .o_duration_ms   (o_duration_ms),
        .o_index_invalid (o_index_invalid),
        .o_end_of_song   (o_end_of_song)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Command written into a full queue.");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("Command taken from an empty queue.");

    a_invalid_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_index_invalid) |-> (o_tone_index == '0))
        else $error("Out-of-range note carries a nonzero tone index.");

    a_index_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tone_index <= rtttl_pkg::TONE_W'(48)))
        else $error("Tone index beyond the tone table.");

endmodule
